[rtl/cca_pkg.sv]
// Shared types, codes and constants of the cave smoothing automaton.
package cca_pkg;

	// Fixed widths of the word fields and the registers.
	localparam int ROW_W     = 6;
	localparam int COL_W     = 6;
	localparam int CNT_W     = 7;
	localparam int THR_W     = 4;
	localparam int NBR_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 7;

	// Default grid bounds of the storage.
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// Register reset values.
	localparam logic [CNT_W-1:0] DEF_ROW_COUNT = CNT_W'(64);
	localparam logic [CNT_W-1:0] DEF_COL_COUNT = CNT_W'(64);
	localparam logic [THR_W-1:0] DEF_GROW      = THR_W'(4);
	localparam logic [THR_W-1:0] DEF_ERODE     = THR_W'(3);

	// Command codes.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_RUN   = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROW      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERODE     = 2'd3;

	// Neighbour offset codes: one less, same, one more.
	localparam logic [1:0] OFF_NEG = 2'd0;
	localparam logic [1:0] OFF_MID = 2'd1;
	localparam logic [1:0] OFF_POS = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             cell_in;
	} cmd_word_t;

	typedef struct packed {
		logic cell_out;
		logic status;
	} rsp_word_t;

	// One read request to the grid memory.
	typedef struct packed {
		logic             en;
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
	} mem_rd_t;

	// Status of the neighbour counting unit toward the sequencer.
	typedef struct packed {
		logic last;
		logic new_cell;
	} nbr_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDATA,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_RESP
	} state_t;

endpackage

[rtl/cca_grid_mem.sv]
// Single-bit grid storage with one write port and one registered read port.
module cca_grid_mem
	import cca_pkg::*;
#(
	parameter int ROW_AW = 6,
	parameter int COL_AW = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [CNT_W-1:0] wr_row,
	input  logic [CNT_W-1:0] wr_col,
	input  logic             wr_data,
	input  mem_rd_t          rd_req,
	output logic             rd_data
);

	localparam int DEPTH  = 1 << (ROW_AW + COL_AW);
	localparam int ROW_XW = (ROW_AW > CNT_W) ? ROW_AW : CNT_W;
	localparam int COL_XW = (COL_AW > CNT_W) ? COL_AW : CNT_W;

	logic                       mem [DEPTH];
	logic [ROW_XW-1:0]          wr_row_x;
	logic [COL_XW-1:0]          wr_col_x;
	logic [ROW_XW-1:0]          rd_row_x;
	logic [COL_XW-1:0]          rd_col_x;
	logic [ROW_AW+COL_AW-1:0]   wr_addr;
	logic [ROW_AW+COL_AW-1:0]   rd_addr;

	// Rows are strided by a power of two so the address is a plain concatenation.
	assign wr_row_x = ROW_XW'(wr_row);
	assign wr_col_x = COL_XW'(wr_col);
	assign rd_row_x = ROW_XW'(rd_req.row);
	assign rd_col_x = COL_XW'(rd_req.col);
	assign wr_addr  = {wr_row_x[ROW_AW-1:0], wr_col_x[COL_AW-1:0]};
	assign rd_addr  = {rd_row_x[ROW_AW-1:0], rd_col_x[COL_AW-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/cca_nbr_count.sv]
// Neighbour walker: steps through the 3x3 window, reads it and counts walls.
module cca_nbr_count
	import cca_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             issue,
	input  logic [CNT_W-1:0] pos_row,
	input  logic [CNT_W-1:0] pos_col,
	input  logic [CNT_W-1:0] rows_use,
	input  logic [CNT_W-1:0] cols_use,
	input  logic [THR_W-1:0] grow_wall_above,
	input  logic [THR_W-1:0] erode_wall_below,
	input  logic             rd_data,
	output mem_rd_t          rd_req,
	output nbr_stat_t        stat
);

	logic [1:0]       dr_q;
	logic [1:0]       dc_q;
	logic             take_s1;
	logic             ctr_s1;
	logic [NBR_W-1:0] acc_q;
	logic             centre_q;
	logic [CNT_W:0]   row_p1;
	logic [CNT_W:0]   col_p1;
	logic             row_ok;
	logic             col_ok;
	logic             centre;
	logic             first;
	logic             in_bounds;

	assign row_p1 = {1'b0, pos_row} + (CNT_W+1)'(1);
	assign col_p1 = {1'b0, pos_col} + (CNT_W+1)'(1);

	// Neighbours past the edge of the grid in use are skipped, not read.
	assign row_ok = !(dr_q == OFF_NEG && pos_row == '0) &&
		!(dr_q == OFF_POS && row_p1 == {1'b0, rows_use});
	assign col_ok = !(dc_q == OFF_NEG && pos_col == '0) &&
		!(dc_q == OFF_POS && col_p1 == {1'b0, cols_use});

	assign centre    = (dr_q == OFF_MID) && (dc_q == OFF_MID);
	assign first     = (dr_q == OFF_NEG) && (dc_q == OFF_NEG);
	assign in_bounds = row_ok && col_ok;

	always_comb begin
		rd_req.en = issue && in_bounds;
		case (dr_q)
			OFF_NEG: rd_req.row = pos_row - CNT_W'(1);
			OFF_POS: rd_req.row = row_p1[CNT_W-1:0];
			default: rd_req.row = pos_row;
		endcase
		case (dc_q)
			OFF_NEG: rd_req.col = pos_col - CNT_W'(1);
			OFF_POS: rd_req.col = col_p1[CNT_W-1:0];
			default: rd_req.col = pos_col;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dr_q    <= OFF_NEG;
			dc_q    <= OFF_NEG;
			take_s1 <= 1'b0;
			ctr_s1  <= 1'b0;
		end else begin
			take_s1 <= issue && in_bounds && !centre;
			ctr_s1  <= issue && centre;
			if (issue) begin
				if (dc_q == OFF_POS) begin
					dc_q <= OFF_NEG;
					dr_q <= (dr_q == OFF_POS) ? OFF_NEG : dr_q + 2'd1;
				end else begin
					dc_q <= dc_q + 2'd1;
				end
			end
		end
	end

	// Read data lands in the cycle after its request, tagged by the _s1 flags.
	always_ff @(posedge clk) begin
		if (issue && first) begin
			acc_q <= '0;
		end else if (take_s1 && rd_data) begin
			acc_q <= acc_q + NBR_W'(1);
		end
		if (ctr_s1) begin
			centre_q <= rd_data;
		end
	end

	assign stat.last     = (dr_q == OFF_POS) && (dc_q == OFF_POS);
	assign stat.new_cell = centre_q ? !(acc_q < erode_wall_below) : (acc_q > grow_wall_above);

endmodule

[rtl/cave_cellular_automaton_pass_top.sv]
// Top level of the cave smoothing automaton: handshakes, registers and sequencer.
// A write word is done in the accept cycle, a read lands in the read-data state, and a run
// walks every cell of the grid in use; an empty grid goes straight to the response.
// Each cell of a run takes nine window steps through the single memory read port, a drain
// state for the last read to land and a write-back state.
// One command word is in work at a time; the next is taken once the response is staged.
// Reset restores the four registers to 64, 64, 4 and 3; the grid contents are not cleared.
module cave_cellular_automaton_pass_top
	import cca_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_word_t            cmd_word,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_word_t            rsp_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// The storage address width follows from the bounds. The grid in use can never
	// exceed what the size registers can express, so the limits are clamped to that.
	localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_MAX  = (1 << CNT_W) - 1;
	localparam int LIM_ROWS = (MAX_ROWS < CNT_MAX) ? MAX_ROWS : CNT_MAX;
	localparam int LIM_COLS = (MAX_COLS < CNT_MAX) ? MAX_COLS : CNT_MAX;
	localparam logic [CNT_W-1:0] LIM_ROWS_V = CNT_W'(LIM_ROWS);
	localparam logic [CNT_W-1:0] LIM_COLS_V = CNT_W'(LIM_COLS);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] row_count_q;
	logic [CNT_W-1:0] col_count_q;
	logic [THR_W-1:0] grow_q;
	logic [THR_W-1:0] erode_q;
	logic [CNT_W-1:0] rows_use;
	logic [CNT_W-1:0] cols_use;
	logic [CNT_W-1:0] pos_row_q;
	logic [CNT_W-1:0] pos_col_q;
	logic [CNT_W:0]   pos_row_p1;
	logic [CNT_W:0]   pos_col_p1;
	logic             last_col;
	logic             last_row;
	rsp_word_t        res_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_word_q;

	logic             cmd_take;
	logic             cell_cmd;
	logic             addr_bad;
	logic             grid_empty;
	logic [CNT_W-1:0] cmd_row_x;
	logic [CNT_W-1:0] cmd_col_x;

	logic             mem_wr_en;
	logic [CNT_W-1:0] mem_wr_row;
	logic [CNT_W-1:0] mem_wr_col;
	logic             mem_wr_data;
	mem_rd_t          mem_rd;
	mem_rd_t          nbr_rd;
	logic             mem_rd_data;
	logic             nbr_issue;
	nbr_stat_t        nbr_stat;

	logic             pos_clear;
	logic             pos_step;
	logic             res_take_rd;
	logic             rsp_load;

	// Grid size in use: each size register saturates at the storage bound.
	assign rows_use = (row_count_q > LIM_ROWS_V) ? LIM_ROWS_V : row_count_q;
	assign cols_use = (col_count_q > LIM_COLS_V) ? LIM_COLS_V : col_count_q;
	assign grid_empty = (rows_use == '0) || (cols_use == '0);

	// Address check for single cell reads and writes, on the live command word.
	assign cmd_row_x = CNT_W'(cmd_word.row);
	assign cmd_col_x = CNT_W'(cmd_word.col);
	assign cell_cmd  = (cmd_word.cmd == CMD_WRITE) || (cmd_word.cmd == CMD_READ);
	assign addr_bad  = (cmd_row_x >= rows_use) || (cmd_col_x >= cols_use);
	assign cmd_take  = cmd_valid && !cmd_stall;

	// Raster position of the pass.
	assign pos_row_p1 = {1'b0, pos_row_q} + (CNT_W+1)'(1);
	assign pos_col_p1 = {1'b0, pos_col_q} + (CNT_W+1)'(1);
	assign last_col   = (pos_col_p1 == {1'b0, cols_use});
	assign last_row   = (pos_row_p1 == {1'b0, rows_use});

	// Configuration registers are plain writes; the port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DEF_ROW_COUNT;
			col_count_q <= DEF_COL_COUNT;
			grow_q      <= DEF_GROW;
			erode_q     <= DEF_ERODE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data[CNT_W-1:0];
				REG_COL_COUNT: col_count_q <= cfg_data[CNT_W-1:0];
				REG_GROW:      grow_q      <= cfg_data[THR_W-1:0];
				REG_ERODE:     erode_q     <= cfg_data[THR_W-1:0];
				default:       ;
			endcase
		end
	end

	// Sequencer. A command word is taken only in idle. A cell write is done in
	// the accept cycle, a cell read is issued there and lands in the read-data
	// state. A run walks the grid: each cell steps the neighbour unit through its
	// window, waits for the last read, then writes the new value back in place,
	// so later cells see the updated neighbours above and to the left.
	always_comb begin
		state_d     = state_q;
		cmd_stall   = 1'b1;
		mem_wr_en   = 1'b0;
		mem_wr_row  = cmd_row_x;
		mem_wr_col  = cmd_col_x;
		mem_wr_data = cmd_word.cell_in;
		mem_rd      = nbr_rd;
		nbr_issue   = 1'b0;
		pos_clear   = 1'b0;
		pos_step    = 1'b0;
		res_take_rd = 1'b0;
		rsp_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_stall  = 1'b0;
				mem_rd.en  = cmd_valid && (cmd_word.cmd == CMD_READ) && !addr_bad;
				mem_rd.row = cmd_row_x;
				mem_rd.col = cmd_col_x;
				mem_wr_en  = cmd_valid && (cmd_word.cmd == CMD_WRITE) && !addr_bad;
				pos_clear  = 1'b1;
				if (cmd_valid) begin
					if (cmd_word.cmd == CMD_READ && !addr_bad) begin
						state_d = ST_RDATA;
					end else if (cmd_word.cmd == CMD_RUN && !grid_empty) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_RDATA: begin
				res_take_rd = 1'b1;
				state_d     = ST_RESP;
			end
			ST_SCAN: begin
				nbr_issue = 1'b1;
				if (nbr_stat.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				mem_wr_en   = 1'b1;
				mem_wr_row  = pos_row_q;
				mem_wr_col  = pos_col_q;
				mem_wr_data = nbr_stat.new_cell;
				pos_step    = 1'b1;
				state_d     = (last_col && last_row) ? ST_RESP : ST_SCAN;
			end
			ST_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_row_q <= '0;
			pos_col_q <= '0;
		end else if (pos_clear) begin
			pos_row_q <= '0;
			pos_col_q <= '0;
		end else if (pos_step) begin
			if (last_col) begin
				pos_col_q <= '0;
				pos_row_q <= pos_row_p1[CNT_W-1:0];
			end else begin
				pos_col_q <= pos_col_p1[CNT_W-1:0];
			end
		end
	end

	// Pending response: status is known at accept, read data in the following cycle.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			res_q.cell_out <= 1'b0;
			res_q.status   <= cell_cmd && addr_bad;
		end else if (res_take_rd) begin
			res_q.cell_out <= mem_rd_data;
		end
	end

	// Output register: parts the response side from the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_word_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	cca_nbr_count u_nbr (
		.clk              (clk),
		.arst_n           (arst_n),
		.issue            (nbr_issue),
		.pos_row          (pos_row_q),
		.pos_col          (pos_col_q),
		.rows_use         (rows_use),
		.cols_use         (cols_use),
		.grow_wall_above  (grow_q),
		.erode_wall_below (erode_q),
		.rd_data          (mem_rd_data),
		.rd_req           (nbr_rd),
		.stat             (nbr_stat)
	);

	cca_grid_mem #(
		.ROW_AW (ROW_AW),
		.COL_AW (COL_AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_row  (mem_wr_row),
		.wr_col  (mem_wr_col),
		.wr_data (mem_wr_data),
		.rd_req  (mem_rd),
		.rd_data (mem_rd_data)
	);

`ifndef SYNTH
	// An accepted word always moves the sequencer out of idle.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after taking a command word");

	// The write-back never collides with a window read of the pass.
	a_no_wr_rd_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> !nbr_rd.en)
		else $error("grid write and neighbour read in the same cycle");

	// During a pass the current cell lies inside the grid in use.
	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (pos_row_q < rows_use) && (pos_col_q < cols_use))
		else $error("pass position outside the grid in use");

	// A new response word appears only when the sequencer hands one over.
	a_rsp_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESP))
		else $error("response word raised without a finished command");
`endif

endmodule
